>>> src/cfsc_pkg.sv
`default_nettype none
package cfsc_pkg;

    // Request codes
    localparam logic [1:0] REQ_WATCH  = 2'd0;
    localparam logic [1:0] REQ_UPDATE = 2'd1;
    localparam logic [1:0] REQ_GET    = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // Field widths
    localparam int BUS_W   = 8;
    localparam int IDENT_W = 29;
    localparam int LEN_W   = 4;
    localparam int DATA_W  = 64;
    localparam int KEY_W   = BUS_W + IDENT_W;
    localparam int FRAME_W = LEN_W + DATA_W;

    // One result beat
    typedef struct packed {
        logic [1:0]        status;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] payload;
    } t_result;

endpackage
`default_nettype wire

>>> src/cfsc_ram.sv
`default_nettype none
module cfsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                     i_wdata,
    input  wire logic                                 i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

>>> src/cfsc_seq.sv
`default_nettype none
module cfsc_seq #(
    parameter int CACHE_ENTRIES = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic [1:0]              i_req_type,
    input  wire logic [7:0]              i_bus_num,
    input  wire logic [28:0]             i_frame_key,
    input  wire logic [3:0]              i_frame_len,
    input  wire logic [63:0]             i_frame_payload,
    output logic                         o_res_valid,
    input  wire logic                    i_res_ready,
    output cfsc_pkg::t_result            o_res
);
    import cfsc_pkg::*;

    localparam int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int CW = $clog2(CACHE_ENTRIES + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_FETCH = 2'd2;
    localparam logic [1:0] S_RESP  = 2'd3;

    logic [1:0]               r_state, n_state;
    logic [CW-1:0]            r_issue, n_issue;
    logic                     r_pend,  n_pend;
    logic [IW-1:0]            r_pidx,  n_pidx;
    logic [CW-1:0]            r_cnt,   n_cnt;
    logic [CACHE_ENTRIES-1:0] r_vld,   n_vld;
    logic [1:0]               r_req,   n_req;
    logic [BUS_W-1:0]         r_bus,   n_bus;
    logic [IDENT_W-1:0]       r_key,   n_key;
    logic [LEN_W-1:0]         r_len,   n_len;
    logic [DATA_W-1:0]        r_data,  n_data;
    t_result                  r_res,   n_res;

    logic                     key_we, key_re;
    logic [IW-1:0]            key_raddr;
    logic [KEY_W-1:0]         key_rdata;
    logic                     dat_we, dat_re;
    logic [FRAME_W-1:0]       dat_rdata;
    logic                     match;

    // Key store: scanned one entry per cycle
    cfsc_ram #(.WIDTH(KEY_W), .DEPTH(CACHE_ENTRIES)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (r_cnt[IW-1:0]),
        .i_wdata ({r_bus, r_key}),
        .i_re    (key_re),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    // Frame store: length code over data bytes
    cfsc_ram #(.WIDTH(FRAME_W), .DEPTH(CACHE_ENTRIES)) u_dat_ram (
        .i_clk   (i_clk),
        .i_we    (dat_we),
        .i_waddr (r_pidx),
        .i_wdata ({r_len, r_data}),
        .i_re    (dat_re),
        .i_raddr (r_pidx),
        .o_rdata (dat_rdata)
    );

    // Shared key comparator on the entry read last cycle
    assign match = r_pend && (key_rdata == {r_bus, r_key});

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_RESP);
    assign o_res       = r_res;

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_issue   = r_issue;
        n_pend    = r_pend;
        n_pidx    = r_pidx;
        n_cnt     = r_cnt;
        n_vld     = r_vld;
        n_req     = r_req;
        n_bus     = r_bus;
        n_key     = r_key;
        n_len     = r_len;
        n_data    = r_data;
        n_res     = r_res;
        key_we    = 1'b0;
        key_re    = 1'b0;
        key_raddr = r_issue[IW-1:0];
        dat_we    = 1'b0;
        dat_re    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req           = i_req_type;
                    n_bus           = i_bus_num;
                    n_key           = i_frame_key;
                    n_len           = i_frame_len;
                    n_data          = i_frame_payload;
                    n_issue         = '0;
                    n_pend          = 1'b0;
                    n_res.status    = ST_MISS;
                    n_res.len       = '0;
                    n_res.payload   = '0;
                    if (i_req_type == REQ_UNUSED) begin
                        n_state = S_RESP;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                if (match) begin
                    // hit on entry r_pidx
                    n_pend  = 1'b0;
                    n_state = S_RESP;
                    unique case (r_req)
                        REQ_WATCH: begin
                            n_res.status = ST_OK;
                        end
                        REQ_UPDATE: begin
                            dat_we        = 1'b1;
                            n_vld[r_pidx] = 1'b1;
                            n_res.status  = ST_OK;
                        end
                        REQ_GET: begin
                            if (r_vld[r_pidx]) begin
                                dat_re  = 1'b1;
                                n_state = S_FETCH;
                            end
                        end
                        default: begin
                            n_res.status = ST_MISS;
                        end
                    endcase
                end else if (r_issue < r_cnt) begin
                    // read the next used entry
                    key_re  = 1'b1;
                    n_pend  = 1'b1;
                    n_pidx  = r_issue[IW-1:0];
                    n_issue = r_issue + CW'(1);
                end else begin
                    // all used entries checked, no match
                    n_pend  = 1'b0;
                    n_state = S_RESP;
                    if (r_req == REQ_WATCH) begin
                        if (r_cnt < CW'(CACHE_ENTRIES)) begin
                            key_we                = 1'b1;
                            n_vld[r_cnt[IW-1:0]]  = 1'b0;
                            n_cnt                 = r_cnt + CW'(1);
                            n_res.status          = ST_OK;
                        end else begin
                            n_res.status = ST_FULL;
                        end
                    end
                end
            end

            S_FETCH: begin
                n_res.status  = ST_OK;
                n_res.len     = dat_rdata[FRAME_W-1:DATA_W];
                n_res.payload = dat_rdata[DATA_W-1:0];
                n_state       = S_RESP;
            end

            S_RESP: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
            r_cnt   <= '0;
            r_vld   <= '0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_cnt   <= n_cnt;
            r_vld   <= n_vld;
        end
    end

    // Request and result payload
    always_ff @(posedge i_clk) begin
        r_issue <= n_issue;
        r_pidx  <= n_pidx;
        r_req   <= n_req;
        r_bus   <= n_bus;
        r_key   <= n_key;
        r_len   <= n_len;
        r_data  <= n_data;
        r_res   <= n_res;
    end

endmodule
`default_nettype wire

>>> src/can_frame_snapshot_cache_unit.sv
// An unused request type skips the scan and is answered with a miss;
//   any other request scans the used entries (at most the fill count), and a get
//   that hits a valid entry also reads its frame from the frame store.
// Throughput: one request at a time, one key compare per cycle; the input stalls
//   until the request's result has been passed to the output register.
// Reset (synchronous, active low) clears the fill count, valid bits and handshake state.
`default_nettype none
module can_frame_snapshot_cache_unit #(
    parameter int CACHE_ENTRIES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [7:0]  i_bus_num,
    input  wire logic [28:0] i_frame_key,
    input  wire logic [3:0]  i_frame_len,
    input  wire logic [63:0] i_frame_payload,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    output logic [3:0]       o_out_len,
    output logic [63:0]      o_out_payload
);
    import cfsc_pkg::*;

    logic    res_valid;
    logic    res_ready;
    t_result res;
    logic    r_out_valid;
    t_result r_out;

    cfsc_seq #(.CACHE_ENTRIES(CACHE_ENTRIES)) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_bus_num       (i_bus_num),
        .i_frame_key     (i_frame_key),
        .i_frame_len     (i_frame_len),
        .i_frame_payload (i_frame_payload),
        .o_res_valid     (res_valid),
        .i_res_ready     (res_ready),
        .o_res           (res)
    );

    // Output register loads when empty or being drained
    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out.status;
    assign o_out_len     = r_out.len;
    assign o_out_payload = r_out.payload;

endmodule
`default_nettype wire

>>> tb/can_frame_snapshot_cache_check.sv
// Watches both channels of the frame cache, keeps its own copy of the key store,
// predicts one result per request beat and compares the result beats in order.
module can_frame_snapshot_cache_check #(
    parameter int ENTRIES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [7:0]  i_bus_num,
    input  wire logic [28:0] i_frame_key,
    input  wire logic [3:0]  i_frame_len,
    input  wire logic [63:0] i_frame_payload,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [1:0]  i_status,
    input  wire logic [3:0]  i_out_len,
    input  wire logic [63:0] i_out_payload,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked
);

    // Shadow key store
    logic        slot_used  [ENTRIES];
    logic        slot_valid [ENTRIES];
    logic [7:0]  slot_bus   [ENTRIES];
    logic [28:0] slot_ident [ENTRIES];
    logic [3:0]  slot_len   [ENTRIES];
    logic [63:0] slot_data  [ENTRIES];

    cfsc_pkg::t_result cached_results[$];
    int fail_count = 0;
    int checked = 0;

    // One line per mismatch
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    // Apply one request to the shadow store and return the result it causes
    function automatic cfsc_pkg::t_result apply_request(
        input logic [1:0]  req,
        input logic [7:0]  bus,
        input logic [28:0] ident,
        input logic [3:0]  len,
        input logic [63:0] data
    );
        cfsc_pkg::t_result r;
        int hit;
        int spare;
        r.status  = cfsc_pkg::ST_MISS;
        r.len     = '0;
        r.payload = '0;
        hit   = -1;
        spare = -1;
        // descending scan leaves the lowest index in spare
        for (int k = ENTRIES - 1; k >= 0; k--) begin
            if (slot_used[k] && slot_bus[k] == bus && slot_ident[k] == ident)
                hit = k;
            if (!slot_used[k])
                spare = k;
        end
        case (req)
            cfsc_pkg::REQ_WATCH: begin
                if (hit >= 0) begin
                    r.status = cfsc_pkg::ST_OK;
                end else if (spare >= 0) begin
                    slot_used[spare]  = 1'b1;
                    slot_valid[spare] = 1'b0;
                    slot_bus[spare]   = bus;
                    slot_ident[spare] = ident;
                    r.status = cfsc_pkg::ST_OK;
                end else begin
                    r.status = cfsc_pkg::ST_FULL;
                end
            end
            cfsc_pkg::REQ_UPDATE: begin
                if (hit >= 0) begin
                    slot_len[hit]   = len;
                    slot_data[hit]  = data;
                    slot_valid[hit] = 1'b1;
                    r.status = cfsc_pkg::ST_OK;
                end
            end
            cfsc_pkg::REQ_GET: begin
                if (hit >= 0 && slot_valid[hit]) begin
                    r.status  = cfsc_pkg::ST_OK;
                    r.len     = slot_len[hit];
                    r.payload = slot_data[hit];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Channel monitor: results are checked before the new request is predicted
    always @(posedge i_clk) begin
        cfsc_pkg::t_result want;
        if (!i_rst_n) begin
            for (int k = 0; k < ENTRIES; k++) begin
                slot_used[k]  = 1'b0;
                slot_valid[k] = 1'b0;
            end
            cached_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                checked++;
                if (cached_results.size() == 0) begin
                    report_mismatch("result beat with nothing expected, status",
                                    64'(i_status), 64'(cfsc_pkg::ST_OK));
                end else begin
                    want = cached_results.pop_front();
                    if (i_status !== want.status)
                        report_mismatch("status", 64'(i_status), 64'(want.status));
                    if (i_out_len !== want.len)
                        report_mismatch("out_len", 64'(i_out_len), 64'(want.len));
                    if (i_out_payload !== want.payload)
                        report_mismatch("out_payload", i_out_payload, want.payload);
                end
            end
            if (i_in_valid && !i_in_stall)
                cached_results.push_back(apply_request(i_req_type, i_bus_num, i_frame_key,
                                                       i_frame_len, i_frame_payload));
        end
        o_pending    <= cached_results.size();
        o_fail_count <= fail_count;
        o_checked    <= checked;
    end

endmodule

>>> tb/can_frame_snapshot_cache_unit_test.sv
// Stimulus and verdict for the frame cache; prediction lives in the checker.
module can_frame_snapshot_cache_unit_test;

    localparam int ENTRIES    = 16;
    localparam int KEY_POOL   = 20;
    localparam int QUIET_MAX  = 4000;
    localparam int TAIL_WAIT  = 2 * ENTRIES + 10;
    localparam logic [28:0] IDENT_MAX = 29'h1FFF_FFFF;

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic        i_out_stall     = 1'b0;
    logic [1:0]  i_req_type      = cfsc_pkg::REQ_GET;
    logic [7:0]  i_bus_num       = '0;
    logic [28:0] i_frame_key     = '0;
    logic [3:0]  i_frame_len     = '0;
    logic [63:0] i_frame_payload = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_status;
    logic [3:0]  o_out_len;
    logic [63:0] o_out_payload;

    int fails;
    int pending;
    int results_seen;
    int quiet_cycles  = 0;
    int in_idle_pct   = 0;
    int out_idle_pct  = 0;
    int req_count[4]  = '{0, 0, 0, 0};

    logic [7:0]  pool_bus   [KEY_POOL];
    logic [28:0] pool_ident [KEY_POOL];

    can_frame_snapshot_cache_unit #(
        .CACHE_ENTRIES(ENTRIES)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_bus_num       (i_bus_num),
        .i_frame_key     (i_frame_key),
        .i_frame_len     (i_frame_len),
        .i_frame_payload (i_frame_payload),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_out_len       (o_out_len),
        .o_out_payload   (o_out_payload)
    );

    can_frame_snapshot_cache_check #(
        .ENTRIES(ENTRIES)
    ) u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_bus_num       (i_bus_num),
        .i_frame_key     (i_frame_key),
        .i_frame_len     (i_frame_len),
        .i_frame_payload (i_frame_payload),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_status        (o_status),
        .i_out_len       (o_out_len),
        .i_out_payload   (o_out_payload),
        .o_fail_count    (fails),
        .o_pending       (pending),
        .o_checked       (results_seen)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_idle_pct);
    end

    // Watchdog: cycles in which no beat moves on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_MAX) @(posedge i_clk);
        $display("timeout: no beat moved for %0d cycles", QUIET_MAX);
        $display("can_frame_snapshot_cache_unit_test: errors");
        $finish;
    end

    // Present one request beat, with a random gap first, and hold it until accepted
    task automatic send_request(input logic [1:0] req, input logic [7:0] bus,
                                input logic [28:0] ident, input logic [3:0] len,
                                input logic [63:0] data);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_req_type      <= req;
        i_bus_num       <= bus;
        i_frame_key     <= ident;
        i_frame_len     <= len;
        i_frame_payload <= data;
        req_count[req]++;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Hold off the sender until every outstanding result is back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Mostly requests on a small key pool so watches, updates and gets meet;
    // the rest is noise: random keys with any request code, the unused one included
    task automatic random_request();
        int pick;
        int sel;
        logic [1:0]  req;
        logic [7:0]  bus;
        logic [28:0] ident;
        logic [3:0]  len;
        pick  = $urandom_range(99);
        sel   = $urandom_range(KEY_POOL - 1);
        bus   = pool_bus[sel];
        ident = pool_ident[sel];
        if (pick < 30) begin
            req = cfsc_pkg::REQ_WATCH;
        end else if (pick < 60) begin
            req = cfsc_pkg::REQ_UPDATE;
        end else if (pick < 88) begin
            req = cfsc_pkg::REQ_GET;
        end else begin
            req   = 2'($urandom_range(3));
            bus   = 8'($urandom);
            ident = 29'($urandom);
        end
        if ($urandom_range(4) == 0)
            len = 4'($urandom_range(15, 9));
        else
            len = 4'($urandom_range(8));
        send_request(req, bus, ident, len, {$urandom, $urandom});
    endtask

    task automatic random_phase(input int count, input int in_pct, input int out_pct);
        in_idle_pct  = in_pct;
        out_idle_pct = out_pct;
        repeat (count) random_request();
        drain_results();
    endtask

    initial begin
        // Key pool: some keys share a bus or an identifier with a neighbor
        for (int k = 0; k < KEY_POOL; k++) begin
            pool_bus[k]   = 8'($urandom);
            pool_ident[k] = 29'($urandom);
            if (k % 4 == 1)
                pool_bus[k] = pool_bus[k - 1];
            else if (k % 4 == 2)
                pool_ident[k] = pool_ident[k - 1];
            else if (k % 4 == 3)
                pool_ident[k] = 29'($urandom_range(2047));
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        in_idle_pct  = 32;
        out_idle_pct = 77;

        // Directed: misses on an empty store, watch twice, not-yet-valid get,
        // extreme keys and lengths, partial key matches, unused request code
        send_request(cfsc_pkg::REQ_GET,    8'h00, 29'h0, 4'd0, 64'h0);
        send_request(cfsc_pkg::REQ_UPDATE, 8'hFF, IDENT_MAX, 4'd8, {64{1'b1}});
        send_request(cfsc_pkg::REQ_WATCH,  8'h00, 29'h0, 4'd15, {64{1'b1}});
        send_request(cfsc_pkg::REQ_GET,    8'h00, 29'h0, 4'd0, 64'h0);
        send_request(cfsc_pkg::REQ_WATCH,  8'h00, 29'h0, 4'd0, 64'h0);
        send_request(cfsc_pkg::REQ_UPDATE, 8'h00, 29'h0, 4'd8, {64{1'b1}});
        send_request(cfsc_pkg::REQ_GET,    8'h00, 29'h0, 4'd0, 64'h0);
        send_request(cfsc_pkg::REQ_WATCH,  8'hFF, IDENT_MAX, 4'd0, 64'h0);
        send_request(cfsc_pkg::REQ_UPDATE, 8'hFF, IDENT_MAX, 4'd15, 64'h0);
        send_request(cfsc_pkg::REQ_GET,    8'hFF, IDENT_MAX, 4'd8, {64{1'b1}});
        send_request(cfsc_pkg::REQ_WATCH,  8'h00, IDENT_MAX, 4'd0, 64'h0);
        send_request(cfsc_pkg::REQ_GET,    8'h00, IDENT_MAX, 4'd0, 64'h0);
        send_request(cfsc_pkg::REQ_GET,    8'hFF, 29'h0, 4'd0, 64'h0);
        send_request(cfsc_pkg::REQ_UNUSED, 8'h00, 29'h0, 4'd0, 64'h0);
        send_request(cfsc_pkg::REQ_UPDATE, 8'h00, 29'h0, 4'd0, 64'h0123_4567_89AB_CDEF);
        send_request(cfsc_pkg::REQ_GET,    8'h00, 29'h0, 4'd15, {64{1'b1}});
        send_request(cfsc_pkg::REQ_UPDATE, 8'h00, IDENT_MAX, 4'd9, 64'hFEDC_BA98_7654_3210);
        send_request(cfsc_pkg::REQ_GET,    8'h00, IDENT_MAX, 4'd0, 64'h0);
        send_request(cfsc_pkg::REQ_UNUSED, 8'hFF, IDENT_MAX, 4'd15, {64{1'b1}});
        drain_results();

        // Random: the store fills up early and later watches see it full
        random_phase(135, 32, 77);
        random_phase(135, 77, 32);
        random_phase(140, 0, 0);

        repeat (TAIL_WAIT) @(posedge i_clk);

        $display("sent %0d requests: %0d watch, %0d update, %0d get, %0d unused code",
                 req_count[0] + req_count[1] + req_count[2] + req_count[3],
                 req_count[0], req_count[1], req_count[2], req_count[3]);
        $display("%0d results checked over a %0d-key pool against %0d entries, %0d errors",
                 results_seen, KEY_POOL, ENTRIES, fails + pending);
        if (fails == 0 && pending == 0)
            $display("can_frame_snapshot_cache_unit_test: clean");
        else
            $display("can_frame_snapshot_cache_unit_test: errors");
        $finish;
    end

endmodule
